// ===== hw/rtl/ldrb_pkg.sv =====
package ldrb_pkg;

  localparam int DEF_PANEL_WIDTH  = 64;
  localparam int DEF_PANEL_HEIGHT = 32;
  localparam int DEF_MAX_SCALE    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDED_DOTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_RADIUS_SQ4 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOOM_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOOM_STRENGTH = 3'd5;

  localparam logic [1:0] FN_LOAD_CELL = 2'd0;
  localparam logic [1:0] FN_LOAD_RAMP = 2'd1;
  localparam logic [1:0] FN_QUERY     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  cell_x;
    logic [4:0]  cell_y;
    logic [15:0] packed_color;
    logic [7:0]  ramp_index;
    logic [7:0]  ramp_level;
    logic [9:0]  out_x;
    logic [8:0]  out_y;
  } ldrb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_of_range;
  } ldrb_out_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(v/3) for v below 64
  function automatic logic [4:0] div3(input logic [5:0] v);
    logic [11:0] p;
    p = 12'(v) * 12'd43;
    return p[11:7];
  endfunction

endpackage

// ===== hw/rtl/ldrb_stream_if.sv =====
interface ldrb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/ldrb_ram.sv =====
module ldrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/led_dot_render_with_bloom.sv =====
// LED dot panel preview renderer with bloom.
// Input channel in_item carries one transaction per operation: func 0 loads a
// panel cell (RGB565, corrected through the ramp table), func 1 writes one
// ramp table entry, func 2 queries one upscaled output pixel. Only queries
// produce a transaction on out_item; func 3 is dropped.
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// write them only while the block is idle (the block does not enforce this).
// Work per transaction, from accept until the block is idle again: a ramp load
// writes in the accept cycle; a cell load does three reads of the single ramp
// port plus the cell write; a query runs the bit-serial division of x/s and y/s
// side by side on one counter, a setup step, a scan of the 3x3 neighborhood
// through the one read port of the cell memory, a pipeline drain and a result
// step. An out of range query goes straight to the result step.
// After reset the cell memory is cleared, one entry per cycle, over all
// PANEL_WIDTH*PANEL_HEIGHT entries (2048 by default); in_item.ready stays low
// meanwhile. The ramp table is not cleared.
// The result sits in an output register; a stalled receiver only holds the
// block once the next query result is ready.
module led_dot_render_with_bloom #(
  parameter int PANEL_WIDTH  = ldrb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = ldrb_pkg::DEF_PANEL_HEIGHT,
  parameter int MAX_SCALE    = ldrb_pkg::DEF_MAX_SCALE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ldrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldrb_pkg::CFG_DATA_W-1:0] cfg_data,
  ldrb_stream_if.sink                    in_item,
  ldrb_stream_if.source                  out_item
);
  import ldrb_pkg::*;

  localparam int CELLS = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SW    = $clog2(MAX_SCALE + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LD0, ST_LD1, ST_LD2, ST_LD3,
    ST_DIV, ST_PREP, ST_SCAN, ST_DRAIN, ST_FINISH
  } state_t;

  state_t state;

  logic [4:0] dot_scale;
  logic       rounded_dots;
  logic [9:0] dot_radius_sq4;
  logic [7:0] background_level;
  logic       bloom_enable;
  logic [8:0] bloom_strength;

  logic [CAW-1:0] clr_cnt;
  logic [CAW-1:0] ld_addr;
  logic [15:0]    pk;
  logic [7:0]     rr, gg;

  logic [9:0]    qx, qy;
  logic [SW-1:0] rem_x, rem_y;
  logic [3:0]    dvcnt;

  logic lx, rx, ty, by, in_dot;
  logic [1:0] ci, ri;
  logic dcnt;
  logic oor;

  logic        tag_center, tag_bloom;
  logic [23:0] base;
  logic        pv;
  logic [16:0] pr, pg, pb;
  logic [11:0] acc_r, acc_g, acc_b;

  logic      ov;
  ldrb_out_t od;

  logic           ramp_we;
  logic [7:0]     ramp_raddr, ramp_rdata;
  logic           cell_we;
  logic [CAW-1:0] cell_waddr, cell_raddr;
  logic [23:0]    cell_wdata, cell_rdata;

  logic          acc_in;
  logic [SW-1:0] s;
  logic [15:0]   lim_x, lim_y;
  logic          q_oor;
  logic [SW:0]   tx, ty_d;
  logic          gex, gey;
  logic [4:0]    h;
  logic signed [7:0]  ox, oy;
  logic signed [15:0] sq_x, sq_y;
  logic        [16:0] rad_sum;
  logic [10:0] nx, ny;
  logic [19:0] scan_full;
  logic        colok, rowok;
  logic [8:0]  k;
  logic [12:0] sr, sg, sb;

  assign acc_in        = in_item.valid && in_item.ready;
  assign in_item.ready = (state == ST_IDLE);
  assign out_item.valid = ov;
  assign out_item.data  = od;

  always_comb begin
    if (dot_scale == 5'd0) begin
      s = SW'(1);
    end else if (6'(dot_scale) > 6'(MAX_SCALE)) begin
      s = SW'(MAX_SCALE);
    end else begin
      s = SW'(dot_scale);
    end
  end

  assign lim_x = 16'(PANEL_WIDTH) * 16'(s);
  assign lim_y = 16'(PANEL_HEIGHT) * 16'(s);
  assign q_oor = (16'(in_item.data.out_x) >= lim_x) || (16'(in_item.data.out_y) >= lim_y);

  assign tx   = {rem_x, qx[9]};
  assign ty_d = {rem_y, qy[9]};
  assign gex  = tx >= {1'b0, s};
  assign gey  = ty_d >= {1'b0, s};

  always_comb begin
    h = div3(6'(s));
    if (h == 5'd0) begin
      h = 5'd1;
    end
  end

  assign ox      = $signed(8'({rem_x, 1'b0})) - $signed(8'(s)) + 8'sd1;
  assign oy      = $signed(8'({rem_y, 1'b0})) - $signed(8'(s)) + 8'sd1;
  assign sq_x    = 16'(ox) * 16'(ox);
  assign sq_y    = 16'(oy) * 16'(oy);
  assign rad_sum = 17'($unsigned(sq_x)) + 17'($unsigned(sq_y));

  assign nx        = 11'(qx) + 11'(ci) - 11'd1;
  assign ny        = 11'(qy) + 11'(ri) - 11'd1;
  assign scan_full = 20'(ny) * 20'(PANEL_WIDTH) + 20'(nx);
  assign cell_raddr = scan_full[CAW-1:0];
  assign colok = (ci == 2'd0) ? lx : ((ci == 2'd2) ? rx : 1'b1);
  assign rowok = (ri == 2'd0) ? ty : ((ri == 2'd2) ? by : 1'b1);
  assign k     = (bloom_strength > 9'd256) ? 9'd256 : bloom_strength;

  assign sr = 13'(base[23:16]) + 13'(acc_r);
  assign sg = 13'(base[15:8])  + 13'(acc_g);
  assign sb = 13'(base[7:0])   + 13'(acc_b);

  assign ramp_we = acc_in && (in_item.data.func == FN_LOAD_RAMP);

  always_comb begin
    unique case (state)
      ST_LD1:  ramp_raddr = widen6(pk[10:5]);
      ST_LD2:  ramp_raddr = widen5(pk[4:0]);
      default: ramp_raddr = widen5(pk[15:11]);
    endcase
  end

  assign cell_we    = (state == ST_CLEAR) || (state == ST_LD3);
  assign cell_waddr = (state == ST_CLEAR) ? clr_cnt : ld_addr;
  assign cell_wdata = (state == ST_CLEAR) ? 24'd0 : {rr, gg, ramp_rdata};

  ldrb_ram #(.WIDTH(8), .DEPTH(256)) u_ramp (
    .clk   (clk),
    .we    (ramp_we),
    .waddr (in_item.data.ramp_index),
    .wdata (in_item.data.ramp_level),
    .raddr (ramp_raddr),
    .rdata (ramp_rdata)
  );

  ldrb_ram #(.WIDTH(24), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_cnt          <= '0;
      ov               <= 1'b0;
      tag_center       <= 1'b0;
      tag_bloom        <= 1'b0;
      pv               <= 1'b0;
      dot_scale        <= 5'd8;
      rounded_dots     <= 1'b0;
      dot_radius_sq4   <= 10'd64;
      background_level <= 8'd0;
      bloom_enable     <= 1'b0;
      bloom_strength   <= 9'd64;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_DOT_SCALE:      dot_scale        <= cfg_data[4:0];
          CFG_ROUNDED_DOTS:   rounded_dots     <= cfg_data[0];
          CFG_DOT_RADIUS_SQ4: dot_radius_sq4   <= cfg_data;
          CFG_BACKGROUND:     background_level <= cfg_data[7:0];
          CFG_BLOOM_ENABLE:   bloom_enable     <= cfg_data[0];
          CFG_BLOOM_STRENGTH: bloom_strength   <= cfg_data[8:0];
          default: ;
        endcase
      end

      if (ov && out_item.ready) begin
        ov <= 1'b0;
      end

      // neighborhood pipeline: read data, product, accumulate
      tag_center <= 1'b0;
      tag_bloom  <= 1'b0;
      if (tag_center) begin
        base <= (cell_rdata != 24'd0 && in_dot) ? cell_rdata
              : {background_level, background_level, background_level};
      end
      pv <= tag_bloom && (cell_rdata != 24'd0);
      pr <= 17'(cell_rdata[23:16]) * 17'(k);
      pg <= 17'(cell_rdata[15:8])  * 17'(k);
      pb <= 17'(cell_rdata[7:0])   * 17'(k);
      if (pv) begin
        acc_r <= acc_r + 12'(pr[16:8]);
        acc_g <= acc_g + 12'(pg[16:8]);
        acc_b <= acc_b + 12'(pb[16:8]);
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CAW'(1);
          if (clr_cnt == CAW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_in) begin
            unique case (in_item.data.func)
              FN_LOAD_CELL: begin
                pk      <= in_item.data.packed_color;
                ld_addr <= CAW'(20'(in_item.data.cell_y) * 20'(PANEL_WIDTH)
                                + 20'(in_item.data.cell_x));
                if (32'(in_item.data.cell_x) < PANEL_WIDTH
                    && 32'(in_item.data.cell_y) < PANEL_HEIGHT) begin
                  state <= ST_LD0;
                end
              end
              FN_QUERY: begin
                qx    <= in_item.data.out_x;
                qy    <= {1'b0, in_item.data.out_y};
                rem_x <= '0;
                rem_y <= '0;
                dvcnt <= 4'd0;
                oor   <= q_oor;
                state <= q_oor ? ST_FINISH : ST_DIV;
              end
              default: ;
            endcase
          end
        end
        ST_LD0: state <= ST_LD1;
        ST_LD1: begin
          rr    <= ramp_rdata;
          state <= ST_LD2;
        end
        ST_LD2: begin
          gg    <= ramp_rdata;
          state <= ST_LD3;
        end
        ST_LD3: state <= ST_IDLE;
        ST_DIV: begin
          qx    <= {qx[8:0], gex};
          qy    <= {qy[8:0], gey};
          rem_x <= gex ? SW'(tx - {1'b0, s}) : tx[SW-1:0];
          rem_y <= gey ? SW'(ty_d - {1'b0, s}) : ty_d[SW-1:0];
          dvcnt <= dvcnt + 4'd1;
          if (dvcnt == 4'd9) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          lx <= (6'(rem_x) < 6'(h)) && (qx != 10'd0);
          rx <= (6'(rem_x) >= 6'(s) - 6'(h)) && (11'(qx) + 11'd1 < 11'(PANEL_WIDTH));
          ty <= (6'(rem_y) < 6'(h)) && (qy != 10'd0);
          by <= (6'(rem_y) >= 6'(s) - 6'(h)) && (11'(qy) + 11'd1 < 11'(PANEL_HEIGHT));
          in_dot <= !(rounded_dots && (6'(s) > 6'd2)) || (rad_sum <= 17'(dot_radius_sq4));
          acc_r  <= '0;
          acc_g  <= '0;
          acc_b  <= '0;
          ci     <= 2'd0;
          ri     <= 2'd0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          tag_center <= (ci == 2'd1) && (ri == 2'd1);
          tag_bloom  <= bloom_enable && colok && rowok;
          if (ci == 2'd2) begin
            ci <= 2'd0;
            ri <= ri + 2'd1;
            if (ri == 2'd2) begin
              dcnt  <= 1'b0;
              state <= ST_DRAIN;
            end
          end else begin
            ci <= ci + 2'd1;
          end
        end
        ST_DRAIN: begin
          dcnt <= 1'b1;
          if (dcnt) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!ov || out_item.ready) begin
            ov <= 1'b1;
            od.out_of_range <= oor;
            od.red   <= oor ? 8'd0 : ((sr > 13'd255) ? 8'd255 : sr[7:0]);
            od.green <= oor ? 8'd0 : ((sg > 13'd255) ? 8'd255 : sg[7:0]);
            od.blue  <= oor ? 8'd0 : ((sb > 13'd255) ? 8'd255 : sb[7:0]);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(state == ST_FINISH))
    else $error("result appeared outside the finish step");

  a_oor_black: assert property (@(posedge clk) disable iff (rst)
    ov && od.out_of_range |-> od.red == 8'd0 && od.green == 8'd0 && od.blue == 8'd0)
    else $error("out of range result carries color");

  a_cell_write_order: assert property (@(posedge clk) disable iff (rst)
    cell_we && state != ST_CLEAR |-> $past(state == ST_LD2))
    else $error("cell write without full ramp lookup");

endmodule
